// ----- rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the segment reassembly tracker.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int OP_W             = 1;
  localparam int SEG_OFFSET_W     = 32;
  localparam int SEG_LENGTH_W     = 16;
  localparam int STATUS_W         = 2;
  localparam int SEG_INDEX_W      = 12;
  localparam int RECEIVED_COUNT_W = 13;
  localparam int PRODUCT_BYTES_W  = 32;
  localparam int SEGMENT_BYTES_W  = 16;
  localparam int CFG_INDEX_W      = 8;
  localparam int CFG_DATA_W       = 32;
  localparam int DIV_STEPS        = SEG_OFFSET_W;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_SAVE  = 1'b0;
  localparam logic [OP_W-1:0] OP_CHECK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT_BYTES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_BYTES = 8'd1;

  typedef struct packed {
    logic clr;
    logic in_ready;
    logic load;
    logic div_step;
    logic look;
    logic upd;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_fire;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/srt_if.sv -----
// ----------------------------------------------------------------------------
// srt_if
// Handshake channels: item input, result output and register writes.
// ----------------------------------------------------------------------------
interface srt_item_if;
  import srt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [SEG_OFFSET_W-1:0] seg_offset;
  logic [SEG_LENGTH_W-1:0] seg_length;
  modport source (output valid, op, seg_offset, seg_length, input ready);
  modport sink   (input valid, op, seg_offset, seg_length, output ready);
endinterface

interface srt_result_if;
  import srt_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic                        was_new;
  logic                        present;
  logic [SEG_INDEX_W-1:0]      seg_index;
  logic [RECEIVED_COUNT_W-1:0] received_count;
  logic                        complete;
  modport source (output valid, status, was_new, present, seg_index, received_count,
                  complete, input ready);
  modport sink   (input valid, status, was_new, present, seg_index, received_count,
                  complete, output ready);
endinterface

interface srt_cfg_if;
  import srt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/srt_ctrl.sv -----
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer: bitmap clear, divide, lookup, update, count product, result.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srt_pkg::sts_t  sts_i,
  output srt_pkg::cmd_t  cmd_o
);
  import srt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_fire) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/srt_dp.sv -----
// ----------------------------------------------------------------------------
// srt_dp
// Datapath: registers, bit-serial divider, segment bitmap, count, result.
// ----------------------------------------------------------------------------
module srt_dp #(
  parameter int MAX_SEGMENTS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srt_pkg::cmd_t cmd_i,
  output srt_pkg::sts_t sts_o,
  srt_item_if.sink      item_i,
  srt_result_if.source  result_o,
  srt_cfg_if.sink       cfg_i
);
  import srt_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int MW    = CNT_W + SEGMENT_BYTES_W;
  localparam int CW    = ((MW > PRODUCT_BYTES_W) ? MW : PRODUCT_BYTES_W) + 1;

  logic [PRODUCT_BYTES_W-1:0] prod_bytes_q;
  logic [SEGMENT_BYTES_W-1:0] seg_bytes_q;

  logic [OP_W-1:0]            op_q;
  logic [SEG_OFFSET_W-1:0]    off_q;
  logic [SEG_LENGTH_W-1:0]    len_q;
  logic [SEG_OFFSET_W-1:0]    quo_q;
  logic [SEGMENT_BYTES_W-1:0] rem_q;

  logic                       valid_q, len_ok_q, rd_q;
  logic [IDX_W-1:0]           idx_q, clr_q;
  logic [CNT_W-1:0]           total_q;
  logic [MW-1:0]              mprod_q;
  logic [STATUS_W-1:0]        status_q;
  logic                       new_q, present_q;

  logic                       res_valid_q;
  logic [STATUS_W-1:0]        res_status_q;
  logic                       res_new_q, res_present_q, res_complete_q;
  logic [SEG_INDEX_W-1:0]     res_index_q;
  logic [RECEIVED_COUNT_W-1:0] res_count_q;

  logic                       mem [MAX_SEGMENTS];

  // divider step
  logic [SEGMENT_BYTES_W:0]   sh;
  logic [SEGMENT_BYTES_W+1:0] diff;

  assign sh   = {rem_q, quo_q[SEG_OFFSET_W-1]};
  assign diff = {1'b0, sh} - {2'b00, seg_bytes_q};

  // offset checks after divide
  logic [PRODUCT_BYTES_W-1:0] rest;
  logic [SEGMENT_BYTES_W-1:0] expect_len;
  logic                       offset_ok;

  assign rest       = prod_bytes_q - off_q;
  assign expect_len = (rest < {16'd0, seg_bytes_q}) ? rest[SEGMENT_BYTES_W-1:0] : seg_bytes_q;
  assign offset_ok  = (off_q < prod_bytes_q) && (seg_bytes_q != '0) && (rem_q == '0) &&
                      (quo_q < SEG_OFFSET_W'(MAX_SEGMENTS));

  // update decision
  logic is_new;
  assign is_new = valid_q && (op_q == OP_SAVE) && len_ok_q && !rd_q;

  // completion
  logic [CW-1:0] pe, pb, se;
  logic          complete;

  assign pe = CW'(mprod_q);
  assign pb = CW'(prod_bytes_q);
  assign se = CW'(seg_bytes_q);
  assign complete = (prod_bytes_q == '0) ? (total_q == '0)
                  : ((seg_bytes_q != '0) && (pe >= pb) && ((pe - se) < pb));

  // handshakes
  assign item_i.ready = cmd_i.in_ready;
  assign cfg_i.ready  = 1'b1;

  assign sts_o.in_fire  = item_i.valid & item_i.ready;
  assign sts_o.clr_last = (clr_q == IDX_W'(MAX_SEGMENTS - 1));
  assign sts_o.out_free = !res_valid_q || result_o.ready;

  assign result_o.valid          = res_valid_q;
  assign result_o.status         = res_status_q;
  assign result_o.was_new        = res_new_q;
  assign result_o.present        = res_present_q;
  assign result_o.seg_index      = res_index_q;
  assign result_o.received_count = res_count_q;
  assign result_o.complete       = res_complete_q;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_bytes_q <= '0;
      seg_bytes_q  <= SEGMENT_BYTES_W'(1);
      clr_q        <= '0;
      total_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.reg_index == CFG_PRODUCT_BYTES) begin
          prod_bytes_q <= cfg_i.wdata;
        end else if (cfg_i.reg_index == CFG_SEGMENT_BYTES) begin
          seg_bytes_q <= cfg_i.wdata[SEGMENT_BYTES_W-1:0];
        end
      end
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.upd && is_new) total_q <= total_q + 1'b1;
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= item_i.op;
      off_q <= item_i.seg_offset;
      len_q <= item_i.seg_length;
      quo_q <= item_i.seg_offset;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!diff[SEGMENT_BYTES_W+1]) begin
        rem_q <= diff[SEGMENT_BYTES_W-1:0];
        quo_q <= {quo_q[SEG_OFFSET_W-2:0], 1'b1};
      end else begin
        rem_q <= sh[SEGMENT_BYTES_W-1:0];
        quo_q <= {quo_q[SEG_OFFSET_W-2:0], 1'b0};
      end
    end
    if (cmd_i.look) begin
      valid_q  <= offset_ok;
      idx_q    <= quo_q[IDX_W-1:0];
      len_ok_q <= (len_q == expect_len);
    end
    if (cmd_i.upd) begin
      present_q <= valid_q & rd_q;
      new_q     <= is_new;
      if (!valid_q) begin
        status_q <= ST_BAD_OFFSET;
      end else if ((op_q == OP_SAVE) && !len_ok_q) begin
        status_q <= ST_MISMATCH;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (cmd_i.mul) mprod_q <= MW'(total_q) * MW'(seg_bytes_q);
    if (cmd_i.out_load) begin
      res_status_q   <= status_q;
      res_new_q      <= new_q;
      res_present_q  <= present_q;
      res_index_q    <= valid_q ? SEG_INDEX_W'(idx_q) : '0;
      res_count_q    <= RECEIVED_COUNT_W'(total_q);
      res_complete_q <= complete;
    end
  end

  // segment bitmap
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_q] <= 1'b0;
    end else if (cmd_i.upd && is_new) begin
      mem[idx_q] <= 1'b1;
    end
    if (cmd_i.look) rd_q <= mem[quo_q[IDX_W-1:0]];
  end

endmodule

// ----- rtl/segment_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// segment_reassembly_tracker
// Received-segment bitmap with offset checks, count and completion flag.
// ----------------------------------------------------------------------------
// One item is handled at a time: the next is taken only after the last result is
// loaded; the offset divider in between produces one quotient bit per cycle.
// The next item is taken while a result beat waits on the output register.
// Reset: control registers and count return to reset values, then a clearing
// pass over every entry zeroes the bitmap; no item is taken until it ends.
// Register writes are taken at any time, including during the clearing pass.
module segment_reassembly_tracker #(
  parameter int MAX_SEGMENTS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srt_item_if.sink     item_i,
  srt_result_if.source result_o,
  srt_cfg_if.sink      cfg_i
);
  import srt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  srt_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .item_i   (item_i),
    .result_o (result_o),
    .cfg_i    (cfg_i)
  );

endmodule
